### hw/rtl/tlm_pkg.sv
// Shared constants, register codes and types of the tick latency monitor.
// No dependencies; every module of the block imports this package.
package tlm_pkg;

  localparam int unsigned WINDOW_DEPTH = 16;
  localparam int unsigned BUCKET_TOTAL = 64;

  localparam int unsigned WIN_AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned WIN_CW  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W   = 32 + WIN_CW;
  localparam int unsigned DIV_CW  = $clog2(SUM_W + 1);
  localparam int unsigned BKT_AW  = $clog2(BUCKET_TOTAL);
  localparam int unsigned RUN_W   = 32 + BKT_AW + 8;
  localparam int unsigned PROD_W  = 39;
  localparam int unsigned EDGE_W  = 33;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;
  localparam int unsigned QUEUE_CW    = 2;

  localparam logic [6:0]  PCT_MAX    = 7'd100;
  localparam logic [15:0] STREAK_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    REG_FAST_BOUND,
    REG_SLOW_LIMIT,
    REG_OVERLOAD_THRESHOLD,
    REG_BUCKET_WIDTH,
    REG_PERCENTILE_SELECT,
    REG_DEGRADE_THRESHOLD
  } tlm_reg_e;

  typedef struct packed {
    logic [31:0] fast_bound;
    logic [31:0] slow_limit;
    logic [31:0] overload_threshold;
    logic [15:0] bucket_width;
    logic [6:0]  percentile_select;
    logic [15:0] degrade_threshold;
  } tlm_cfg_t;

  // One classified tick handed from the front to the back.
  typedef struct packed {
    logic [31:0]       duration;
    logic [BKT_AW-1:0] bucket;
    logic [31:0]       min_time;
    logic [31:0]       max_time;
    logic [15:0]       slow_streak;
    logic [15:0]       fast_streak;
    logic              overloaded;
    logic              degraded;
    logic [31:0]       tick_count;
  } tlm_job_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_SEARCH,
    FR_PUSH
  } tlm_front_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SUM,
    BK_DIV,
    BK_HRD,
    BK_HWR,
    BK_PRD,
    BK_SCAN,
    BK_OUT
  } tlm_back_state_e;

endpackage

### hw/rtl/tlm_if.sv
// Channel interfaces of the tick latency monitor: tick input, result output
// and configuration write. No dependencies.
interface tlm_tick_if;
  logic        valid;
  logic        ready;
  logic [31:0] tick_duration;
  modport source (output valid, output tick_duration, input ready);
  modport sink (input valid, input tick_duration, output ready);
endinterface

interface tlm_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] average_time;
  logic [31:0] min_time;
  logic [31:0] max_time;
  logic [15:0] slow_streak;
  logic [15:0] fast_streak;
  logic        overloaded;
  logic        degraded;
  logic [31:0] percentile_time;
  logic [31:0] tick_count;
  modport source (output valid, output average_time, output min_time, output max_time,
                  output slow_streak, output fast_streak, output overloaded,
                  output degraded, output percentile_time, output tick_count,
                  input ready);
  modport sink (input valid, input average_time, input min_time, input max_time,
                input slow_streak, input fast_streak, input overloaded,
                input degraded, input percentile_time, input tick_count,
                output ready);
endinterface

interface tlm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/tlm_front.sv
// Front of the tick latency monitor: accepts ticks, updates min/max, streaks
// and the tick counter, and searches the histogram bucket. Uses tlm_pkg, tlm_if.
module tlm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  tlm_tick_if.sink          tick_i,
  input  tlm_pkg::tlm_cfg_t cfg_i,
  output tlm_pkg::tlm_job_t job_o,
  output logic              job_valid_o,
  input  logic              job_ready_i
);
  import tlm_pkg::*;

  tlm_front_state_e state_q, state_d;
  tlm_job_t         job_q;
  logic [EDGE_W-1:0] edge_q;
  logic [31:0] lowest_q, highest_q, ticks_q;
  logic [15:0] slow_q, fast_q;

  logic [31:0] dur;
  logic [15:0] w_eff;
  logic        accept;
  logic        search_done;
  logic [15:0] slow_d, fast_d;
  logic [31:0] lowest_d, highest_d;

  assign dur    = tick_i.tick_duration;
  assign w_eff  = (cfg_i.bucket_width == 16'd0) ? 16'd1 : cfg_i.bucket_width;
  assign accept = (state_q == FR_IDLE) && tick_i.valid;
  // edge_q holds the lower edge of the bucket after the current one.
  assign search_done = (job_q.bucket == BKT_AW'(BUCKET_TOTAL - 1)) ||
                       ({1'b0, job_q.duration} < edge_q);

  always_comb begin
    slow_d = 16'd0;
    fast_d = 16'd0;
    if (dur > cfg_i.slow_limit) begin
      slow_d = (slow_q == STREAK_MAX) ? slow_q : slow_q + 16'd1;
    end else if (dur < cfg_i.fast_bound) begin
      fast_d = (fast_q == STREAK_MAX) ? fast_q : fast_q + 16'd1;
    end
    lowest_d  = (dur < lowest_q) ? dur : lowest_q;
    highest_d = (dur > highest_q) ? dur : highest_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE:   if (tick_i.valid) state_d = FR_SEARCH;
      FR_SEARCH: if (search_done) state_d = FR_PUSH;
      FR_PUSH:   if (job_ready_i) state_d = FR_IDLE;
      default:   state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    tick_i.ready = 1'b0;
    job_valid_o  = 1'b0;
    case (state_q)
      FR_IDLE: tick_i.ready = 1'b1;
      FR_PUSH: job_valid_o  = 1'b1;
      default: ;
    endcase
  end

  assign job_o = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FR_IDLE;
      lowest_q  <= '1;
      highest_q <= '0;
      ticks_q   <= '0;
      slow_q    <= '0;
      fast_q    <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        lowest_q  <= lowest_d;
        highest_q <= highest_d;
        ticks_q   <= ticks_q + 32'd1;
        slow_q    <= slow_d;
        fast_q    <= fast_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q.duration    <= dur;
      job_q.bucket      <= '0;
      job_q.min_time    <= lowest_d;
      job_q.max_time    <= highest_d;
      job_q.slow_streak <= slow_d;
      job_q.fast_streak <= fast_d;
      job_q.overloaded  <= dur > cfg_i.overload_threshold;
      job_q.degraded    <= slow_d >= cfg_i.degrade_threshold;
      job_q.tick_count  <= ticks_q + 32'd1;
      edge_q            <= EDGE_W'(w_eff);
    end else if ((state_q == FR_SEARCH) && !search_done) begin
      job_q.bucket <= job_q.bucket + BKT_AW'(1);
      edge_q       <= edge_q + EDGE_W'(w_eff);
    end
  end

endmodule

### hw/rtl/tlm_fifo.sv
// Two-entry queue of classified ticks between front and back.
// Uses tlm_pkg for the entry type and depth.
module tlm_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tlm_pkg::tlm_job_t push_data_i,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  output tlm_pkg::tlm_job_t pop_data_o,
  output logic              pop_valid_o,
  input  logic              pop_ready_i
);
  import tlm_pkg::*;

  tlm_job_t            mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q, rd_q;
  logic [QUEUE_CW-1:0] cnt_q;
  logic                push, pop;

  assign push_ready_o = cnt_q != QUEUE_CW'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + QUEUE_AW'(1);
      if (pop) rd_q <= rd_q + QUEUE_AW'(1);
      if (push && !pop) cnt_q <= cnt_q + QUEUE_CW'(1);
      else if (pop && !push) cnt_q <= cnt_q - QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

### hw/rtl/tlm_back.sv
// Back of the tick latency monitor: recent window, moving average divider,
// histogram memory and percentile scan, plus the result register. Uses tlm_pkg, tlm_if.
module tlm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tlm_pkg::tlm_cfg_t cfg_i,
  input  tlm_pkg::tlm_job_t job_i,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  tlm_res_if.source         res_o
);
  import tlm_pkg::*;

  tlm_back_state_e state_q, state_d;
  tlm_job_t        job_q;

  logic [31:0]       win_q [WINDOW_DEPTH];
  logic [WIN_AW-1:0] ptr_q, idx_q;
  logic [SUM_W-1:0]  sum_q, quo_q;
  logic [WIN_CW-1:0] cnt_q, rem_q;
  logic [DIV_CW-1:0] step_q;

  logic [31:0]       hist_mem [BUCKET_TOTAL];
  logic [BUCKET_TOTAL-1:0] hv_q;
  logic [31:0]       hrd_q, total_q, edge_q;
  logic [BKT_AW-1:0] bidx_q, rd_addr;
  logic [RUN_W-1:0]  run_q;
  logic [PROD_W-1:0] prod_q;

  logic        out_valid_q;
  logic [31:0] avg_q, pct_q;

  logic [31:0]       win_val;
  logic              win_nz;
  logic [SUM_W-1:0]  sum_nx;
  logic [WIN_CW-1:0] cnt_nx;
  logic              sum_last;
  logic [WIN_CW:0]   shifted;
  logic              fits;
  logic              div_last;
  logic [31:0]       bkt_cnt;
  logic [RUN_W-1:0]  cnt100, run_nx;
  logic              hit, scan_last;
  logic [6:0]        pct_eff;
  logic [15:0]       w_eff;
  logic              out_free;

  assign w_eff    = (cfg_i.bucket_width == 16'd0) ? 16'd1 : cfg_i.bucket_width;
  assign pct_eff  = (cfg_i.percentile_select > PCT_MAX) ? PCT_MAX : cfg_i.percentile_select;
  assign out_free = !out_valid_q || res_o.ready;

  assign win_val  = win_q[idx_q];
  assign win_nz   = win_val != 32'd0;
  assign sum_nx   = sum_q + (win_nz ? SUM_W'(win_val) : '0);
  assign cnt_nx   = cnt_q + (win_nz ? WIN_CW'(1) : '0);
  assign sum_last = idx_q == WIN_AW'(WINDOW_DEPTH - 1);

  // Restoring divider, one quotient bit per cycle.
  assign shifted  = {rem_q, quo_q[SUM_W-1]};
  assign fits     = shifted >= {1'b0, cnt_q};
  assign div_last = step_q == DIV_CW'(SUM_W - 1);

  // Unwritten buckets read as zero through their valid bits.
  assign bkt_cnt   = hv_q[(state_q == BK_SCAN) ? bidx_q : job_q.bucket] ? hrd_q : 32'd0;
  assign cnt100    = (RUN_W'(bkt_cnt) << 6) + (RUN_W'(bkt_cnt) << 5) + (RUN_W'(bkt_cnt) << 2);
  assign run_nx    = run_q + cnt100;
  // running >= floor(total * pct / 100) is the same as 100 * (running + 1) > total * pct.
  assign hit       = (run_nx + RUN_W'(100)) > RUN_W'(prod_q);
  assign scan_last = bidx_q == BKT_AW'(BUCKET_TOTAL - 1);

  always_comb begin
    case (state_q)
      BK_HRD:  rd_addr = job_q.bucket;
      BK_PRD:  rd_addr = '0;
      default: rd_addr = bidx_q + BKT_AW'(1);
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (job_valid_i) state_d = BK_SUM;
      BK_SUM:  if (sum_last) state_d = BK_DIV;
      BK_DIV:  if (div_last) state_d = BK_HRD;
      BK_HRD:  state_d = BK_HWR;
      BK_HWR:  state_d = BK_PRD;
      BK_PRD:  state_d = (total_q == 32'd0) ? BK_OUT : BK_SCAN;
      BK_SCAN: if (hit || scan_last) state_d = BK_OUT;
      BK_OUT:  if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o = 1'b0;
    case (state_q)
      BK_IDLE: job_ready_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      ptr_q       <= '0;
      hv_q        <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WINDOW_DEPTH; i++) win_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_IDLE && job_valid_i) begin
        win_q[ptr_q] <= job_i.duration;
        ptr_q <= (ptr_q == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : ptr_q + WIN_AW'(1);
      end
      if (state_q == BK_HWR) begin
        hv_q[job_q.bucket] <= 1'b1;
        total_q <= total_q + 32'd1;
      end
      if (state_q == BK_OUT && out_free) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        job_q <= job_i;
        idx_q <= '0;
        sum_q <= '0;
        cnt_q <= '0;
      end
      BK_SUM: begin
        sum_q <= sum_nx;
        cnt_q <= cnt_nx;
        idx_q <= idx_q + WIN_AW'(1);
        if (sum_last) begin
          quo_q  <= sum_nx;
          rem_q  <= '0;
          step_q <= '0;
        end
      end
      BK_DIV: begin
        rem_q  <= fits ? WIN_CW'(shifted - {1'b0, cnt_q}) : WIN_CW'(shifted);
        quo_q  <= {quo_q[SUM_W-2:0], fits};
        step_q <= step_q + DIV_CW'(1);
      end
      BK_HWR: hist_mem[job_q.bucket] <= bkt_cnt + 32'd1;
      BK_PRD: begin
        prod_q <= PROD_W'(total_q) * PROD_W'(pct_eff);
        bidx_q <= '0;
        edge_q <= '0;
        run_q  <= '0;
        pct_q  <= '0;
      end
      BK_SCAN: begin
        if (hit || scan_last) begin
          pct_q <= edge_q;
        end else begin
          bidx_q <= bidx_q + BKT_AW'(1);
          edge_q <= edge_q + 32'(w_eff);
          run_q  <= run_nx;
        end
      end
      default: ;
    endcase
    if (state_q == BK_HRD || state_q == BK_PRD || state_q == BK_SCAN) begin
      hrd_q <= hist_mem[rd_addr];
    end
    if (state_q == BK_OUT && out_free) begin
      avg_q <= (cnt_q == '0) ? job_q.duration : quo_q[31:0];
    end
  end

  // The result fields other than average and percentile come from the held job.
  tlm_job_t res_job_q;
  logic [31:0] res_pct_q;

  always_ff @(posedge clk_i) begin
    if (state_q == BK_OUT && out_free) begin
      res_job_q <= job_q;
      res_pct_q <= pct_q;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.average_time    = avg_q;
  assign res_o.min_time        = res_job_q.min_time;
  assign res_o.max_time        = res_job_q.max_time;
  assign res_o.slow_streak     = res_job_q.slow_streak;
  assign res_o.fast_streak     = res_job_q.fast_streak;
  assign res_o.overloaded      = res_job_q.overloaded;
  assign res_o.degraded        = res_job_q.degraded;
  assign res_o.percentile_time = res_pct_q;
  assign res_o.tick_count      = res_job_q.tick_count;

endmodule

### hw/rtl/tick_latency_monitor_core.sv
// Top level of the tick latency monitor: configuration registers, front,
// queue and back. Uses tlm_pkg, tlm_if, tlm_front, tlm_fifo, tlm_back.
//
//   Channel  Dir  Handshake      Payload
//   tick_i   in   valid/ready    tick_duration[31:0]
//   res_o    out  valid/ready    average, min, max, streaks, flags, percentile, count
//   cfg_i    in   valid/ready    index[2:0], data[31:0]; always ready
//
// The front takes a new tick only when idle, after the bucket search and push of the last one.
// The back works on one tick at a time: window sum, bit-serial divider, histogram
// read and write, and histogram scan over one memory read port.
// Reset is asynchronous; the histogram is cleared by its valid bits at once.
// A stalled result waits in its register while the next tick is worked on.
module tick_latency_monitor_core (
  input  logic clk_i,
  input  logic rst_ni,
  tlm_tick_if.sink  tick_i,
  tlm_res_if.source res_o,
  tlm_cfg_if.sink   cfg_i
);
  import tlm_pkg::*;

  tlm_cfg_t cfg_q;
  tlm_job_t fr_job, bk_job;
  logic     fr_valid, fr_ready, bk_valid, bk_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_bound         <= 32'd50000;
      cfg_q.slow_limit         <= 32'd100000;
      cfg_q.overload_threshold <= 32'd75000;
      cfg_q.bucket_width       <= 16'd1000;
      cfg_q.percentile_select  <= 7'd50;
      cfg_q.degrade_threshold  <= 16'd5;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_FAST_BOUND:         cfg_q.fast_bound         <= cfg_i.data;
        REG_SLOW_LIMIT:         cfg_q.slow_limit         <= cfg_i.data;
        REG_OVERLOAD_THRESHOLD: cfg_q.overload_threshold <= cfg_i.data;
        REG_BUCKET_WIDTH:       cfg_q.bucket_width       <= cfg_i.data[15:0];
        REG_PERCENTILE_SELECT:  cfg_q.percentile_select  <= cfg_i.data[6:0];
        REG_DEGRADE_THRESHOLD:  cfg_q.degrade_threshold  <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  tlm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick_i),
    .cfg_i       (cfg_q),
    .job_o       (fr_job),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready)
  );

  tlm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (fr_job),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .pop_data_o   (bk_job),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready)
  );

  tlm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (bk_job),
    .job_valid_i (bk_valid),
    .job_ready_o (bk_ready),
    .res_o       (res_o)
  );

endmodule
